// ===== design/pipt_pkg.sv =====
// shared constants for the point-in-polygon test core
// no dependencies; imported by point_in_polygon_test_core
package pipt_pkg;

  // polygon table geometry and coordinate format
  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;

  // fixed field widths of the interface
  localparam int VIDX_W = 6;
  localparam int CFG_W  = 7;

  // derived widths
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int ENTRY_W = 2 * COORD_BITS;

  // operation codes of an input transaction
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ===== design/point_in_polygon_test_core.sv =====
// point-in-polygon test core: vertex table, edge walk sequencer, shared multiplier
// depends on pipt_pkg and pipt_ram
//
// Usage: one input channel (in_valid / in_stall) carries either a vertex
// write (in_op = 0: in_vertex_index, in_vertex_x, in_vertex_y) or a query
// (in_op = 1: in_point_x, in_point_y). A vertex write gives no result. A query
// gives one result transaction on the output channel (out_valid / out_stall)
// with out_inside_res = 1 when the point lies inside the polygon by the
// even-odd rule.
// The vertex count is written on the cfg channel (cfg_valid / cfg_ready /
// cfg_data); the user must write it only while the core is idle; the core
// does not enforce this, and cfg_ready is always high. A query loads vertex
// 0, then walks the edges: an edge that does not straddle the query y takes
// only the load step, one that does also passes the multiply steps and the
// compare step; a query with a vertex count of zero skips the walk.
// The edge loop reads one vertex per cycle from the table ram, holding while a
// straddling edge is worked; one signed 17x17 multiplier does both cross products.
// in_stall is high while a query is in flight; a finished result sits in
// the output register, so the next transaction is taken while it waits.
// Reset clears the vertex count to zero and empties the output register;
// the vertex table keeps unknown contents until written.
module point_in_polygon_test_core
  import pipt_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [VIDX_W-1:0]            in_vertex_index,
  input  logic signed [COORD_BITS-1:0] in_vertex_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_y,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_inside_res,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_W-1:0]             cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_MUL_A = 5'b00100,
    ST_MUL_B = 5'b01000,
    ST_CMP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  logic [CFG_W-1:0] count_r;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             odd_r, odd_nxt;

  logic signed [COORD_BITS-1:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, first_x_nxt, first_y_nxt;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r, prev_x_nxt, prev_y_nxt;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, rd_x, rd_y;

  logic signed [DIFF_W-1:0] da_r, db_r, dc_r, ddy_r;
  logic signed [DIFF_W-1:0] da_nxt, db_nxt, dc_nxt, ddy_nxt;
  logic signed [DIFF_W-1:0] mul_op_a, mul_op_b;
  logic signed [PROD_W-1:0] mul_r, lhs_r, mul_nxt, lhs_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_inside_r, out_inside_nxt;

  logic               in_accept, wr_en, straddle, crosses, out_free;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // vertex table, one entry holds {x, y}
  pipt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_vertex_x, in_vertex_y}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // handshake and port drive
  assign in_stall       = (state_r != ST_IDLE) || done_r;
  assign in_accept      = in_valid && !in_stall;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_free       = !out_valid_r || !out_stall;

  // vertex writes beyond the table are dropped
  assign wr_en   = in_accept && (in_op == OP_WRITE) && (int'(in_vertex_index) < MAX_VERTICES);
  assign wr_addr = IDX_W'(in_vertex_index);

  // the address always follows the next edge index, so read data matches k_r
  assign rd_addr = k_nxt[IDX_W-1:0];
  assign rd_x    = rd_data[ENTRY_W-1:COORD_BITS];
  assign rd_y    = rd_data[COORD_BITS-1:0];

  // far end of the current edge, the closing edge wraps to vertex 0
  assign cur_x = (k_r == n_r) ? first_x_r : rd_x;
  assign cur_y = (k_r == n_r) ? first_y_r : rd_y;

  // half-open straddle test against the query y
  assign straddle = ((prev_y_r < py_r) && (cur_y >= py_r)) ||
                    ((cur_y < py_r) && (prev_y_r >= py_r));

  // shared multiplier operand select
  assign mul_op_a = (state_r == ST_MUL_A) ? da_r : dc_r;
  assign mul_op_b = (state_r == ST_MUL_A) ? db_r : ddy_r;

  // crossing lies left of the query point, direction set by the sign of dy
  assign crosses = ddy_r[DIFF_W-1] ? (mul_r < lhs_r) : (lhs_r < mul_r);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    done_nxt       = done_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    odd_nxt        = odd_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    da_nxt         = da_r;
    db_nxt         = db_r;
    dc_nxt         = dc_r;
    ddy_nxt        = ddy_r;
    mul_nxt        = mul_r;
    lhs_nxt        = lhs_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_inside_nxt = out_inside_r;

    unique case (state_r)
      ST_IDLE: begin
        if (done_r) begin
          // hand the parity to the output register once it is free
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_inside_nxt = odd_r;
            done_nxt       = 1'b0;
          end
        end else if (in_accept && (in_op == OP_QUERY)) begin
          px_nxt  = in_point_x;
          py_nxt  = in_point_y;
          odd_nxt = 1'b0;
          k_nxt   = '0;
          n_nxt   = (int'(count_r) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(count_r);
          if (count_r == '0) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (k_r == '0) begin
          // vertex 0 opens the walk and closes it again at the end
          first_x_nxt = rd_x;
          first_y_nxt = rd_y;
          prev_x_nxt  = rd_x;
          prev_y_nxt  = rd_y;
          k_nxt       = k_r + 1'b1;
        end else begin
          da_nxt  = DIFF_W'(py_r) - DIFF_W'(prev_y_r);
          db_nxt  = DIFF_W'(cur_x) - DIFF_W'(prev_x_r);
          dc_nxt  = DIFF_W'(px_r) - DIFF_W'(prev_x_r);
          ddy_nxt = DIFF_W'(cur_y) - DIFF_W'(prev_y_r);
          prev_x_nxt = cur_x;
          prev_y_nxt = cur_y;
          if (straddle) begin
            state_nxt = ST_MUL_A;
          end else if (k_r == n_r) begin
            state_nxt = ST_IDLE;
            done_nxt  = 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      ST_MUL_A: begin
        mul_nxt   = mul_op_a * mul_op_b;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        lhs_nxt   = mul_r;
        mul_nxt   = mul_op_a * mul_op_b;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (crosses) begin
          odd_nxt = !odd_r;
        end
        if (k_r == n_r) begin
          state_nxt = ST_IDLE;
          done_nxt  = 1'b1;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    odd_r        <= odd_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    first_x_r    <= first_x_nxt;
    first_y_r    <= first_y_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_y_r     <= prev_y_nxt;
    da_r         <= da_nxt;
    db_r         <= db_nxt;
    dc_r         <= dc_nxt;
    ddy_r        <= ddy_nxt;
    mul_r        <= mul_nxt;
    lhs_r        <= lhs_nxt;
    out_inside_r <= out_inside_nxt;
  end

`ifndef ASSERT_OFF
  // the edge index never runs past the vertex count
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (k_r <= n_r))
    else $error("edge index beyond vertex count");

  // a query transaction holds the input side off on the next cycle
  a_query_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_op == OP_QUERY)) |=> in_stall)
    else $error("query accepted without stalling the input");

  // a vertex write keeps the core ready for the next transaction
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_op == OP_WRITE)) |=> !in_stall)
    else $error("vertex write left the core busy");

  // a result only appears after the walk has finished
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done_r))
    else $error("result issued without a finished walk");
`endif

endmodule

// ===== design/pipt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; holds the polygon vertex table
module pipt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
